/* src/span_copy_chunk_generator_defines.svh */
// assertion macros for the span copy chunk generator
`ifndef SPAN_COPY_CHUNK_GENERATOR_DEFINES_SVH
`define SPAN_COPY_CHUNK_GENERATOR_DEFINES_SVH

`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* src/scc_pkg.sv */
package scc_pkg;

  localparam int unsigned MaxSpanDefault = 1024;
  localparam int unsigned ChunkPixels    = 32;
  localparam int unsigned MaxResults     = 64;
  localparam int unsigned CoordWidth     = 12;
  localparam int unsigned WidthWidth     = 11;
  localparam int unsigned PitchWidth     = 13;
  localparam int unsigned AddrWidth      = 32;
  localparam int unsigned DoneWidth      = 12;
  localparam int unsigned CntWidth       = 7;
  localparam logic [PitchWidth-1:0] PitchReset = 13'd1024;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic out_busy;
  } sts_t;

endpackage

/* src/scc_ctrl.sv */
module scc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_stall_i,
  output logic          in_stall_o,
  output scc_pkg::cmd_t cmd_o,
  input  scc_pkg::sts_t sts_i
);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StInit,
    StWalk
  } state_e;

  state_e state_q;
  logic   slot_free;

  assign slot_free  = !sts_i.out_busy || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == StIdle) && in_valid_i;
    cmd_o.init = (state_q == StInit);
    cmd_o.step = (state_q == StWalk) && !sts_i.fin && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StMul;
        end
        StMul:  state_q <= StInit;
        StInit: state_q <= StWalk;
        StWalk: begin
          if (sts_i.fin) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

/* src/scc_datapath.sv */
module scc_datapath #(
  parameter int unsigned MaxSpan = scc_pkg::MaxSpanDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scc_pkg::cmd_t                     cmd_i,
  output scc_pkg::sts_t                     sts_o,
  input  logic                              cfg_valid_i,
  input  logic [scc_pkg::PitchWidth-1:0]    cfg_line_pitch_i,
  input  logic                              kind_i,
  input  logic [scc_pkg::CoordWidth-1:0]    src_x_i,
  input  logic [scc_pkg::CoordWidth-1:0]    src_y_i,
  input  logic [scc_pkg::CoordWidth-1:0]    dst_x_i,
  input  logic [scc_pkg::CoordWidth-1:0]    dst_y_i,
  input  logic [scc_pkg::WidthWidth-1:0]    span_width_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [2:0]                        shift_amount_o,
  output logic [31:0]                       src_address_o,
  output logic [31:0]                       src_mask_o,
  output logic [31:0]                       dst_address_o,
  output logic [31:0]                       dst_mask_o,
  output logic                              last_o
);

  localparam logic [scc_pkg::WidthWidth-1:0] SpanCap = scc_pkg::WidthWidth'(MaxSpan);
  localparam logic [31:0] Chunk = 32'(scc_pkg::ChunkPixels);
  localparam logic [scc_pkg::CntWidth-1:0] CntMax = scc_pkg::CntWidth'(scc_pkg::MaxResults);

  logic [scc_pkg::PitchWidth-1:0] pitch_q;
  logic                           kind_q;
  logic [scc_pkg::CoordWidth-1:0] sx_q, sy_q, dx_q, dy_q;
  logic [scc_pkg::WidthWidth-1:0] w_q;
  logic [31:0]                    a1_q, a2_q, src_q, dst_q;
  logic [scc_pkg::DoneWidth-1:0]  done_q;
  logic                           prime_done_q;
  logic [scc_pkg::CntWidth-1:0]   cnt_q;
  logic                           out_valid_q;

  logic [31:0] a1w, a2w, w32;
  logic [scc_pkg::DoneWidth-1:0] wd, rem, next_done;
  logic        rem_full;
  logic [2:0]  sa, da;
  logic [3:0]  sa4, da4;

  logic [31:0] f_s, f_d, f_sm, f_dm, f_ns, f_nd;
  logic [2:0]  f_ps;
  logic [5:0]  f_adv;

  logic [31:0] b_s, b_d, b_sm, b_dm, b_ns, b_nd;
  logic [2:0]  b_ps;
  logic [5:0]  b_adv;
  logic        prime;

  logic [2:0]  c_ps;
  logic [31:0] c_s, c_sm, c_d, c_dm, c_ns, c_nd;
  logic [5:0]  c_adv;
  logic        c_last;

  assign w32  = {21'b0, w_q};
  assign wd   = {1'b0, w_q};
  assign a1w  = a1_q + w32;
  assign a2w  = a2_q + w32;
  assign rem  = wd - done_q;
  assign rem_full = (rem >= scc_pkg::DoneWidth'(scc_pkg::ChunkPixels));
  assign sa   = src_q[2:0];
  assign da   = dst_q[2:0];
  assign sa4  = {1'b0, sa};
  assign da4  = {1'b0, da};

  // forward walk
  always_comb begin
    f_dm = rem_full ? scc_pkg::AllOnes : (scc_pkg::AllOnes >> (6'd32 - rem[5:0]));
    f_s  = src_q - {29'b0, sa};
    f_sm = scc_pkg::AllOnes << sa;
    f_d  = dst_q - {29'b0, da};
    f_dm = f_dm << da;
    if (da >= sa) begin
      f_ps  = da - sa;
      f_adv = 6'd32 - {3'b0, da};
    end else begin
      f_ps  = 3'(4'd8 - sa4 + da4);
      f_d   = f_d - 32'd8;
      f_dm  = f_dm << 8;
      f_adv = 6'd24 - {3'b0, da};
    end
    f_ns = f_s + Chunk - {29'b0, f_ps};
    f_nd = f_d + Chunk;
  end

  // backward walk
  always_comb begin
    prime = (done_q == '0) && (da != 3'd0) && (sa > da);
    b_s  = src_q;
    b_d  = dst_q;
    b_sm = scc_pkg::AllOnes;
    b_dm = rem_full ? scc_pkg::AllOnes : (scc_pkg::AllOnes << (6'd32 - rem[5:0]));
    if (prime) begin
      b_s  = b_s + {28'b0, 4'd8 - sa4};
      b_sm = (b_sm >> (4'd8 - sa4)) >> da;
      b_dm = b_dm >> da;
    end else if ((done_q == '0) && (sa != da)) begin
      b_s  = b_s + {28'b0, 4'd8 - sa4};
    end else if (sa != 3'd0) begin
      b_s  = b_s + {28'b0, 4'd8 - sa4};
      b_sm = b_sm >> (4'd8 - sa4);
    end
    if (da != 3'd0) begin
      b_d  = b_d + {28'b0, 4'd8 - da4};
      b_dm = b_dm >> (4'd8 - da4);
    end
    if (da >= sa) begin
      b_ps = da - sa;
    end else begin
      b_ps = 3'(4'd8 - sa4 + da4);
      if (da != 3'd0) begin
        b_s  = b_s + 32'd8;
        b_sm = b_sm >> 8;
      end
    end
    if (da == sa) begin
      b_ns = b_s - 32'd32;
      b_nd = b_d - 32'd32;
    end else begin
      b_ns = b_s - 32'd24;
      b_nd = b_d - (32'd32 - {29'b0, b_ps});
    end
    if (da > sa) begin
      b_adv = (done_q == '0) ? (6'd24 + {3'b0, sa}) : 6'd24;
    end else if (da == sa) begin
      b_adv = ((done_q == '0) && (da != 3'd0)) ? (6'd24 + {3'b0, da}) : 6'd32;
    end else begin
      b_adv = (da != 3'd0) ? (6'd16 + {3'b0, sa}) : (6'd32 - {3'b0, b_ps});
    end
  end

  always_comb begin
    if (kind_q) begin
      c_ps = b_ps; c_s = b_s; c_sm = b_sm; c_d = b_d; c_dm = b_dm;
      c_ns = b_ns; c_nd = b_nd; c_adv = b_adv;
    end else begin
      c_ps = f_ps; c_s = f_s; c_sm = f_sm; c_d = f_d; c_dm = f_dm;
      c_ns = f_ns; c_nd = f_nd; c_adv = f_adv;
    end
    next_done = done_q + {6'b0, c_adv};
    c_last = (cnt_q == CntMax - 1'b1) || (next_done >= wd);
  end

  assign sts_o.fin      = (done_q >= wd) || (cnt_q == CntMax);
  assign sts_o.out_busy = out_valid_q;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q      <= scc_pkg::PitchReset;
      out_valid_q  <= 1'b0;
      done_q       <= '0;
      cnt_q        <= '0;
      prime_done_q <= 1'b0;
    end else begin
      if (cfg_valid_i) pitch_q <= cfg_line_pitch_i;
      if (cmd_i.init) begin
        done_q       <= '0;
        cnt_q        <= '0;
        prime_done_q <= 1'b0;
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + 1'b1;
        if (kind_q && prime && !prime_done_q) begin
          prime_done_q <= 1'b1;
        end else begin
          done_q <= next_done;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      sx_q   <= src_x_i;
      sy_q   <= src_y_i;
      dx_q   <= dst_x_i;
      dy_q   <= dst_y_i;
      w_q    <= (span_width_i > SpanCap) ? SpanCap : span_width_i;
    end
    // linear offsets, registered from the loaded coordinates in the cycle after load
    a1_q <= {7'b0, {13'b0, sy_q} * {12'b0, pitch_q}} + {20'b0, sx_q};
    a2_q <= {7'b0, {13'b0, dy_q} * {12'b0, pitch_q}} + {20'b0, dx_q};
    if (cmd_i.init) begin
      src_q <= kind_q ? (a1w - Chunk) : a1_q;
      dst_q <= kind_q ? (a2w - Chunk) : a2_q;
    end
    if (cmd_i.step) begin
      if (kind_q && prime && !prime_done_q) begin
        shift_amount_o <= 3'(4'd8 - sa4 + da4);
        src_address_o  <= a1w - {29'b0, sa};
        src_mask_o     <= scc_pkg::AllOnes;
        dst_address_o  <= a2w - {29'b0, da} - 32'd8;
        dst_mask_o     <= (32'h0000_00FF >> (4'd8 - da4)) << 8;
        last_o         <= (cnt_q == CntMax - 1'b1);
      end else begin
        shift_amount_o <= c_ps;
        src_address_o  <= c_s;
        src_mask_o     <= c_sm;
        dst_address_o  <= c_d;
        dst_mask_o     <= c_dm;
        last_o         <= c_last;
        src_q          <= c_ns;
        dst_q          <= c_nd;
      end
    end
  end

endmodule

/* src/span_copy_chunk_generator.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | kind, src_x/y, dst_x/y, span_width
// out     | output    | out_valid_o/out_stall_i | shift, addresses, masks, last
// cfg     | input     | cfg_valid_i/cfg_ready_o | line_pitch
//
// one item passes two setup states (offset multiply, start address), then one
// chunk per cycle while out is not stalled, plus a backward priming chunk, and returns idle
// a 1024-pixel span gives up to about 44 chunks, set by the chunk walk loop
// reset is asynchronous active low; line_pitch resets to 1024
// an out stall holds the chunk register and pauses the walk

module span_copy_chunk_generator #(
  parameter int unsigned MaxSpan = scc_pkg::MaxSpanDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [scc_pkg::PitchWidth-1:0]    cfg_line_pitch_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [scc_pkg::CoordWidth-1:0]    src_x_i,
  input  logic [scc_pkg::CoordWidth-1:0]    src_y_i,
  input  logic [scc_pkg::CoordWidth-1:0]    dst_x_i,
  input  logic [scc_pkg::CoordWidth-1:0]    dst_y_i,
  input  logic [scc_pkg::WidthWidth-1:0]    span_width_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        shift_amount_o,
  output logic [31:0]                       src_address_o,
  output logic [31:0]                       src_mask_o,
  output logic [31:0]                       dst_address_o,
  output logic [31:0]                       dst_mask_o,
  output logic                              last_o
);

  scc_pkg::cmd_t cmd;
  scc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  scc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  scc_datapath #(
    .MaxSpan (MaxSpan)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_line_pitch_i (cfg_line_pitch_i),
    .kind_i           (kind_i),
    .src_x_i          (src_x_i),
    .src_y_i          (src_y_i),
    .dst_x_i          (dst_x_i),
    .dst_y_i          (dst_y_i),
    .span_width_i     (span_width_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .shift_amount_o   (shift_amount_o),
    .src_address_o    (src_address_o),
    .src_mask_o       (src_mask_o),
    .dst_address_o    (dst_address_o),
    .dst_mask_o       (dst_mask_o),
    .last_o           (last_o)
  );

endmodule

/* src/scc_checker.sv */
`include "span_copy_chunk_generator_defines.svh"

module scc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] src_address_o,
  input logic        last_o
);

  `SCC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(src_address_o), "stall hold")
  `SCC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")
  `SCC_ASSERT(a_busy_mid_span, out_valid_o && !last_o |-> in_stall_o, "idle with span open")

endmodule

bind span_copy_chunk_generator scc_checker u_scc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .src_address_o (src_address_o),
  .last_o        (last_o)
);

/* test/span_copy_chunk_generator_tb.sv */
module span_copy_chunk_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    WalkForward  = 1'b0,
    WalkBackward = 1'b1
  } walk_e;

  typedef struct packed {
    logic [2:0]  shift_amount;
    logic [31:0] src_address;
    logic [31:0] src_mask;
    logic [31:0] dst_address;
    logic [31:0] dst_mask;
    logic        last;
  } chunk_t;

  localparam int unsigned IdlePct = 8;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 50;
  localparam int unsigned MaxReported = 10;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [scc_pkg::PitchWidth-1:0] cfg_line_pitch_i;
  logic in_valid_i;
  logic in_stall_o;
  logic kind_i;
  logic [scc_pkg::CoordWidth-1:0] src_x_i, src_y_i, dst_x_i, dst_y_i;
  logic [scc_pkg::WidthWidth-1:0] span_width_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [2:0] shift_amount_o;
  logic [31:0] src_address_o, src_mask_o, dst_address_o, dst_mask_o;
  logic last_o;

  chunk_t expected_chunks[$];
  logic [scc_pkg::PitchWidth-1:0] pitch_copy;
  bit quiet;
  int unsigned mismatches;
  int unsigned spans_sent;
  int unsigned chunks_seen;
  int unsigned pitch_writes;
  int unsigned idle_count;

  span_copy_chunk_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_line_pitch_i(cfg_line_pitch_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .src_x_i         (src_x_i),
    .src_y_i         (src_y_i),
    .dst_x_i         (dst_x_i),
    .dst_y_i         (dst_y_i),
    .span_width_i    (span_width_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .shift_amount_o  (shift_amount_o),
    .src_address_o   (src_address_o),
    .src_mask_o      (src_mask_o),
    .dst_address_o   (dst_address_o),
    .dst_mask_o      (dst_mask_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < IdlePct);
  endfunction

  // span chunk prediction, appended to expected_chunks
  task automatic predict_span(input walk_e kind, input logic [11:0] sx, input logic [11:0] sy,
                              input logic [11:0] dx, input logic [11:0] dy,
                              input logic [10:0] width);
    chunk_t span_q[$];
    chunk_t c;
    logic [31:0] a1, a2, src, dst, sm, dm, sa, da, ps, rem, adv, done, w;
    w = (width > scc_pkg::MaxSpanDefault) ? scc_pkg::MaxSpanDefault : width;
    a1 = sy * pitch_copy + sx;
    a2 = dy * pitch_copy + dx;
    done = 0;
    if (kind == WalkForward) begin
      src = a1;
      dst = a2;
      while (done < w) begin
        rem = w - done;
        dm = (rem >= scc_pkg::ChunkPixels) ? scc_pkg::AllOnes :
             (scc_pkg::AllOnes >> (32 - rem));
        sa = src & 7;
        da = dst & 7;
        src = src - sa;
        sm = scc_pkg::AllOnes << sa;
        dst = dst - da;
        dm = dm << da;
        if (da >= sa) begin
          ps = da - sa;
        end else begin
          ps = 8 - (sa - da);
          dst = dst - 8;
          dm = dm << 8;
        end
        c = '{ps[2:0], src, sm, dst, dm, 1'b0};
        if (span_q.size() < scc_pkg::MaxResults) span_q.push_back(c);
        src = src + scc_pkg::ChunkPixels - ps;
        dst = dst + scc_pkg::ChunkPixels;
        done = done + scc_pkg::ChunkPixels - da - ((da < sa) ? 8 : 0);
      end
    end else begin
      src = a1 + w - scc_pkg::ChunkPixels;
      dst = a2 + w - scc_pkg::ChunkPixels;
      while (done < w) begin
        rem = w - done;
        sm = scc_pkg::AllOnes;
        dm = (rem >= scc_pkg::ChunkPixels) ? scc_pkg::AllOnes :
             (scc_pkg::AllOnes << (32 - rem));
        sa = src & 7;
        da = dst & 7;
        if (done == 0 && da != 0 && sa > da) begin
          ps = (8 - sa) + da;
          c = '{ps[2:0], a1 + w - sa, scc_pkg::AllOnes, a2 + w - da - 8,
                (32'h0000_00FF >> (8 - da)) << 8, 1'b0};
          if (span_q.size() < scc_pkg::MaxResults) span_q.push_back(c);
          src = src + 8 - sa;
          sm = sm >> (8 - sa);
          sm = sm >> da;
          dm = dm >> da;
        end else if (done == 0 && sa != da) begin
          src = src + 8 - sa;
        end else if (sa != 0) begin
          src = src + 8 - sa;
          sm = sm >> (8 - sa);
        end
        if (da != 0) begin
          dst = dst + 8 - da;
          dm = dm >> (8 - da);
        end
        if (da >= sa) begin
          ps = da - sa;
        end else begin
          ps = (8 - sa) + da;
          if (da != 0) begin
            src = src + 8;
            sm = sm >> 8;
          end
        end
        c = '{ps[2:0], src, sm, dst, dm, 1'b0};
        if (span_q.size() < scc_pkg::MaxResults) span_q.push_back(c);
        if (da == sa) begin
          src = src - 32;
          dst = dst - 32;
        end else begin
          src = src - 24;
          dst = dst - (32 - ps);
        end
        if (da > sa) adv = (done == 0) ? 24 + sa : 24;
        else if (da == sa) adv = (done == 0 && da != 0) ? 24 + da : 32;
        else adv = (da != 0) ? 16 + sa : 32 - ps;
        done = done + adv;
      end
    end
    if (span_q.size() > 0) span_q[span_q.size() - 1].last = 1'b1;
    foreach (span_q[i]) expected_chunks.push_back(span_q[i]);
  endtask

  task automatic send_span(input walk_e kind, input logic [11:0] sx, input logic [11:0] sy,
                           input logic [11:0] dx, input logic [11:0] dy,
                           input logic [10:0] width);
    @(negedge clk_i);
    while (idle_now()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    src_x_i = sx;
    src_y_i = sy;
    dst_x_i = dx;
    dst_y_i = dy;
    span_width_i = width;
    do @(posedge clk_i); while (in_stall_o);
    predict_span(kind, sx, sy, dx, dy, width);
    spans_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_pitch(input logic [scc_pkg::PitchWidth-1:0] pitch);
    wait (expected_chunks.size() == 0);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_line_pitch_i = pitch;
    do @(posedge clk_i); while (!cfg_ready_o);
    pitch_copy = pitch;
    pitch_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_random_span();
    int unsigned pick;
    logic [10:0] width;
    pick = $urandom_range(99);
    if (pick < 80) width = 11'($urandom_range(64, 1));
    else if (pick < 95) width = 11'($urandom_range(scc_pkg::MaxSpanDefault, 1));
    else width = 11'($urandom_range(2047, 0));
    send_span(walk_e'($urandom_range(1)), 12'($urandom), 12'($urandom), 12'($urandom),
              12'($urandom), width);
  endtask

  task automatic test_forward_alignments();
    send_span(WalkForward, 12'd0, 12'd0, 12'd0, 12'd0, 11'd1);
    send_span(WalkForward, 12'd3, 12'd1, 12'd3, 12'd2, 11'd32);
    send_span(WalkForward, 12'd2, 12'd5, 12'd6, 12'd5, 11'd70);
    send_span(WalkForward, 12'd7, 12'd9, 12'd1, 12'd3, 11'd100);
    send_span(WalkForward, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 11'd1024);
    send_span(WalkForward, 12'd5, 12'd0, 12'd0, 12'd0, 11'd0);
  endtask

  task automatic test_backward_walks();
    send_span(WalkBackward, 12'd0, 12'd0, 12'd0, 12'd0, 11'd5);
    send_span(WalkBackward, 12'd8, 12'd1, 12'd16, 12'd1, 11'd64);
    send_span(WalkBackward, 12'd1, 12'd2, 12'd5, 12'd2, 11'd77);
    send_span(WalkBackward, 12'd6, 12'd3, 12'd2, 12'd3, 11'd45);
    send_span(WalkBackward, 12'd3, 12'd3, 12'd0, 12'd3, 11'd40);
    send_span(WalkBackward, 12'd4095, 12'd4095, 12'd0, 12'd0, 11'd2047);
    send_span(WalkBackward, 12'd0, 12'd0, 12'd0, 12'd0, 11'd0);
  endtask

  task automatic test_pitch_extremes();
    write_pitch(13'd0);
    send_span(WalkForward, 12'd7, 12'd100, 12'd0, 12'd4095, 11'd5);
    send_span(WalkBackward, 12'd1, 12'd50, 12'd6, 12'd9, 11'd20);
    write_pitch(13'd8191);
    send_span(WalkForward, 12'd4095, 12'd4095, 12'd1, 12'd4095, 11'd1025);
    send_span(WalkBackward, 12'd2, 12'd4095, 12'd7, 12'd0, 11'd33);
    write_pitch(13'd1);
    send_span(WalkForward, 12'd0, 12'd0, 12'd3, 12'd0, 11'd31);
    write_pitch(13'd4096);
    send_span(WalkBackward, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 11'd1024);
  endtask

  task automatic test_random_spans();
    logic [scc_pkg::PitchWidth-1:0] pitch;
    for (int phase = 0; phase < 4; phase++) begin
      pitch = (phase == 0) ? 13'd1024 : 13'($urandom);
      write_pitch(pitch);
      quiet = (phase == 1);
      repeat (75) send_random_span();
    end
    quiet = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= idle_now();
  end

  always @(posedge clk_i) begin
    chunk_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{shift_amount_o, src_address_o, src_mask_o, dst_address_o, dst_mask_o, last_o};
      chunks_seen++;
      if (expected_chunks.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) $display("unexpected chunk %p", got);
      end else begin
        want = expected_chunks.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReported) $display("chunk mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_count <= 0;
    end else if (idle_count >= WatchdogLimit) begin
      $display("watchdog: no progress, %0d chunks outstanding", expected_chunks.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_line_pitch_i = '0;
    in_valid_i = 1'b0;
    kind_i = 1'b0;
    src_x_i = '0;
    src_y_i = '0;
    dst_x_i = '0;
    dst_y_i = '0;
    span_width_i = '0;
    pitch_copy = scc_pkg::PitchReset;
    quiet = 1'b0;
    spans_sent = 0;
    pitch_writes = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_forward_alignments();
    test_backward_walks();
    test_pitch_extremes();
    test_random_spans();
    wait (expected_chunks.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d spans in both walk directions, %0d chunks checked",
             spans_sent, chunks_seen);
    $display("line pitch written %0d times, zero and max pitch included", pitch_writes);
    if (mismatches == 0 && expected_chunks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
